[rtl/tsab_pkg.sv]
// Package for the tolerance snap block with adaptive baseline.
// Holds shared widths, configuration register indexes, command codes and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsab_pkg;

    localparam int VALUE_BITS_DEF     = 32;
    localparam int RATE_FRAC_BITS_DEF = 16;
    localparam int SUM_BITS           = 48;
    localparam int CNT_BITS           = 32;
    localparam int CFG_IDX_BITS       = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASELINE_INIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPT_RATE    = 2'd2;

    localparam logic CMD_SNAP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Control flags of one input item.
    typedef struct packed {
        logic command;
        logic expected_given;
        logic reload_baseline;
    } t_item_ctl;

endpackage

`default_nettype wire

[rtl/tsab_in_if.sv]
// Input sample channel: valid/ready handshake with the input item fields.
// Depends on nothing; width comes from the VALUE_BITS parameter.
`timescale 1ns / 1ps
`default_nettype none

interface tsab_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [VALUE_BITS-1:0] sample;
    logic [VALUE_BITS-1:0] expected_value;
    logic                  expected_given;
    logic                  reload_baseline;

    modport source (output valid, command, sample, expected_value, expected_given,
                    reload_baseline, input ready);
    modport sink   (input valid, command, sample, expected_value, expected_given,
                    reload_baseline, output ready);
endinterface

`default_nettype wire

[rtl/tsab_out_if.sv]
// Result channel: valid/ready handshake with the result item fields.
// Uses tsab_pkg for the statistics widths.
`timescale 1ns / 1ps
`default_nettype none

interface tsab_out_if #(
    parameter int VALUE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic [VALUE_BITS-1:0]         snapped_value;
    logic [VALUE_BITS-1:0]         delta;
    logic                          within_res;
    logic [tsab_pkg::CNT_BITS-1:0] snap_total;
    logic [tsab_pkg::CNT_BITS-1:0] miss_total;
    logic [VALUE_BITS-1:0]         peak_delta;
    logic [tsab_pkg::SUM_BITS-1:0] delta_sum;

    modport source (output valid, snapped_value, delta, within_res, snap_total, miss_total,
                    peak_delta, delta_sum, input ready);
    modport sink   (input valid, snapped_value, delta, within_res, snap_total, miss_total,
                    peak_delta, delta_sum, output ready);
endinterface

`default_nettype wire

[rtl/tsab_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Uses tsab_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

interface tsab_cfg_if #(
    parameter int DATA_BITS = 32
);
    logic                              valid;
    logic                              ready;
    logic [tsab_pkg::CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]              data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/tolerance_snap_adaptive_baseline.sv]
// Top level of the tolerance snap block with adaptive baseline.
// Depends on tsab_pkg, tsab_in_if, tsab_out_if, tsab_cfg_if, tsab_cfg_regs
// and tsab_snap_core.
//
// Usage:
//   i_in carries one item per transaction: a snap command with a sample and an
//   optional expected value, or a clear command that zeroes the statistics
//   and optionally reloads the baseline. o_out returns exactly one result
//   transaction per input item, in order. i_cfg writes tolerance (index 0),
//   baseline_init (index 1) and adapt_rate (index 2); it is always ready and
//   should only be written while no items are in flight.
//   An accepted item is captured in the input register, and its result is
//   then registered in the output register, which drives o_out. Throughput
//   is one item per cycle while the receiver does not stall; the baseline
//   update (subtract, multiply by the rate, add) is combinational.
//   When the receiver stalls, the result is held in the output register and
//   the input register holds the next item; i_in.ready drops only when both
//   are full. Reset clears the registers, counters, statistics and baseline
//   to zero and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module tolerance_snap_adaptive_baseline #(
    parameter int VALUE_BITS     = tsab_pkg::VALUE_BITS_DEF,
    parameter int RATE_FRAC_BITS = tsab_pkg::RATE_FRAC_BITS_DEF
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    tsab_in_if.sink      i_in,
    tsab_out_if.source   o_out,
    tsab_cfg_if.sink     i_cfg
);

    localparam int V = VALUE_BITS;
    localparam int C = tsab_pkg::CNT_BITS;
    localparam int S = tsab_pkg::SUM_BITS;
    localparam int CFG_DATA_BITS = (VALUE_BITS > RATE_FRAC_BITS + 1) ?
                                   VALUE_BITS : RATE_FRAC_BITS + 1;

    logic [V-1:0]              w_tolerance;
    logic [V-1:0]              w_baseline_init;
    logic [RATE_FRAC_BITS:0]   w_adapt_rate;

    assign i_cfg.ready = 1'b1;

    tsab_cfg_regs #(
        .VALUE_BITS     (VALUE_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS),
        .DATA_BITS      (CFG_DATA_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (i_cfg.valid),
        .i_index         (i_cfg.index),
        .i_data          (i_cfg.data[CFG_DATA_BITS-1:0]),
        .o_tolerance     (w_tolerance),
        .o_baseline_init (w_baseline_init),
        .o_adapt_rate    (w_adapt_rate)
    );

    // Input register stage.
    logic                r_in_valid;
    tsab_pkg::t_item_ctl r_in_ctl;
    logic [V-1:0]        r_in_sample;
    logic [V-1:0]        r_in_expected;

    // Output register stage.
    logic          r_out_valid;
    logic [V-1:0]  r_out_snapped;
    logic [V-1:0]  r_out_delta;
    logic          r_out_within;
    logic [C-1:0]  r_out_snap;
    logic [C-1:0]  r_out_miss;
    logic [V-1:0]  r_out_peak;
    logic [S-1:0]  r_out_sum;

    logic          w_advance;
    logic          w_fire;
    logic          w_in_take;

    logic [V-1:0]  w_snapped;
    logic [V-1:0]  w_delta;
    logic          w_within;
    logic [C-1:0]  w_snap;
    logic [C-1:0]  w_miss;
    logic [V-1:0]  w_peak;
    logic [S-1:0]  w_sum;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (w_in_take) begin
            r_in_ctl.command         <= i_in.command;
            r_in_ctl.expected_given  <= i_in.expected_given;
            r_in_ctl.reload_baseline <= i_in.reload_baseline;
            r_in_sample              <= i_in.sample;
            r_in_expected            <= i_in.expected_value;
        end
    end

    tsab_snap_core #(
        .VALUE_BITS     (VALUE_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_ctl           (r_in_ctl),
        .i_sample        (r_in_sample),
        .i_expected      (r_in_expected),
        .i_tolerance     (w_tolerance),
        .i_baseline_init (w_baseline_init),
        .i_adapt_rate    (w_adapt_rate),
        .o_snapped       (w_snapped),
        .o_delta         (w_delta),
        .o_within        (w_within),
        .o_snap_total    (w_snap),
        .o_miss_total    (w_miss),
        .o_peak_delta    (w_peak),
        .o_delta_sum     (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_snapped <= w_snapped;
            r_out_delta   <= w_delta;
            r_out_within  <= w_within;
            r_out_snap    <= w_snap;
            r_out_miss    <= w_miss;
            r_out_peak    <= w_peak;
            r_out_sum     <= w_sum;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.snapped_value = r_out_snapped;
    assign o_out.delta         = r_out_delta;
    assign o_out.within_res    = r_out_within;
    assign o_out.snap_total    = r_out_snap;
    assign o_out.miss_total    = r_out_miss;
    assign o_out.peak_delta    = r_out_peak;
    assign o_out.delta_sum     = r_out_sum;

    // A snapped result never reports a delta above the tolerance.
    a_within_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_within) |-> (r_out_delta <= w_tolerance))
        else $error("snapped result with delta above tolerance");

    // The peak delta always covers the delta of the same result.
    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_peak >= r_out_delta))
        else $error("peak delta below current delta");

    // An item held in the input register during a stall is not lost.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_sample)))
        else $error("stalled input item dropped");

endmodule

`default_nettype wire

[rtl/tsab_cfg_regs.sv]
// Configuration register file: tolerance, baseline reload value, adaptation rate.
// Uses tsab_pkg for register indexes.
`timescale 1ns / 1ps
`default_nettype none

module tsab_cfg_regs #(
    parameter int VALUE_BITS     = tsab_pkg::VALUE_BITS_DEF,
    parameter int RATE_FRAC_BITS = tsab_pkg::RATE_FRAC_BITS_DEF,
    parameter int DATA_BITS      = VALUE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr,
    input  wire logic [tsab_pkg::CFG_IDX_BITS-1:0] i_index,
    input  wire logic [DATA_BITS-1:0]              i_data,
    output logic [VALUE_BITS-1:0]                  o_tolerance,
    output logic [VALUE_BITS-1:0]                  o_baseline_init,
    output logic [RATE_FRAC_BITS:0]                o_adapt_rate
);

    logic [VALUE_BITS-1:0]     r_tolerance;
    logic [VALUE_BITS-1:0]     r_baseline_init;
    logic [RATE_FRAC_BITS:0]   r_adapt_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance     <= '0;
            r_baseline_init <= '0;
            r_adapt_rate    <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                tsab_pkg::CFG_TOLERANCE:     r_tolerance     <= i_data[VALUE_BITS-1:0];
                tsab_pkg::CFG_BASELINE_INIT: r_baseline_init <= i_data[VALUE_BITS-1:0];
                tsab_pkg::CFG_ADAPT_RATE:    r_adapt_rate    <= i_data[RATE_FRAC_BITS:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_tolerance     = r_tolerance;
    assign o_baseline_init = r_baseline_init;
    assign o_adapt_rate    = r_adapt_rate;

endmodule

`default_nettype wire

[rtl/tsab_snap_core.sv]
// Snap datapath and running state: baseline, counters, peak and sum of deltas.
// Computes one result per fired item; uses tsab_pkg for widths and codes.
`timescale 1ns / 1ps
`default_nettype none

module tsab_snap_core #(
    parameter int VALUE_BITS     = tsab_pkg::VALUE_BITS_DEF,
    parameter int RATE_FRAC_BITS = tsab_pkg::RATE_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire tsab_pkg::t_item_ctl           i_ctl,
    input  wire logic [VALUE_BITS-1:0]         i_sample,
    input  wire logic [VALUE_BITS-1:0]         i_expected,
    input  wire logic [VALUE_BITS-1:0]         i_tolerance,
    input  wire logic [VALUE_BITS-1:0]         i_baseline_init,
    input  wire logic [RATE_FRAC_BITS:0]       i_adapt_rate,
    output logic [VALUE_BITS-1:0]              o_snapped,
    output logic [VALUE_BITS-1:0]              o_delta,
    output logic                               o_within,
    output logic [tsab_pkg::CNT_BITS-1:0]      o_snap_total,
    output logic [tsab_pkg::CNT_BITS-1:0]      o_miss_total,
    output logic [VALUE_BITS-1:0]              o_peak_delta,
    output logic [tsab_pkg::SUM_BITS-1:0]      o_delta_sum
);

    localparam int V = VALUE_BITS;
    localparam int F = RATE_FRAC_BITS;
    localparam int S = tsab_pkg::SUM_BITS;
    localparam int C = tsab_pkg::CNT_BITS;
    localparam logic [F:0] RATE_ONE = {1'b1, {F{1'b0}}};

    logic [V-1:0] r_baseline;
    logic [C-1:0] r_snap;
    logic [C-1:0] r_miss;
    logic [V-1:0] r_peak;
    logic [S-1:0] r_sum;

    logic [V-1:0] n_baseline;
    logic [C-1:0] n_snap;
    logic [C-1:0] n_miss;
    logic [V-1:0] n_peak;
    logic [S-1:0] n_sum;

    logic [V-1:0]          w_ref;
    logic [V:0]            w_diff;
    logic [V:0]            w_mag;
    logic [V-1:0]          w_delta;
    logic                  w_within;
    logic [V:0]            w_dbase;
    logic [F:0]            w_rate;
    logic signed [V+F+2:0] w_prod;
    logic [V:0]            w_step;
    logic [V:0]            w_base_sum;
    logic [S:0]            w_sum_ext;

    always_comb begin
        w_ref    = i_ctl.expected_given ? i_expected : r_baseline;
        w_diff   = {i_sample[V-1], i_sample} - {w_ref[V-1], w_ref};
        w_mag    = w_diff[V] ? (~w_diff + {{V{1'b0}}, 1'b1}) : w_diff;
        w_delta  = w_mag[V] ? {V{1'b1}} : w_mag[V-1:0];
        w_within = (w_delta <= i_tolerance);

        // On a snap within tolerance, the baseline steps toward the sample, whichever reference was used.
        w_dbase    = {i_sample[V-1], i_sample} - {r_baseline[V-1], r_baseline};
        w_rate     = (i_adapt_rate > RATE_ONE) ? RATE_ONE : i_adapt_rate;
        w_prod     = $signed(w_dbase) * $signed({1'b0, w_rate});
        // Arithmetic shift right by F; the step never exceeds the difference in size.
        w_step     = w_prod[V+F:F];
        w_base_sum = {r_baseline[V-1], r_baseline} + w_step;

        w_sum_ext = {1'b0, r_sum} + (S+1)'(w_delta);

        n_baseline = r_baseline;
        n_snap     = r_snap;
        n_miss     = r_miss;
        n_peak     = r_peak;
        n_sum      = r_sum;
        o_snapped  = '0;
        o_delta    = '0;
        o_within   = 1'b0;

        if (i_ctl.command == tsab_pkg::CMD_CLEAR) begin
            if (i_ctl.reload_baseline) begin
                n_baseline = i_baseline_init;
            end
            n_snap = '0;
            n_miss = '0;
            n_peak = '0;
            n_sum  = '0;
        end else begin
            o_delta   = w_delta;
            o_within  = w_within;
            o_snapped = w_within ? w_ref : i_sample;
            n_peak    = (w_delta > r_peak) ? w_delta : r_peak;
            n_sum     = w_sum_ext[S] ? {S{1'b1}} : w_sum_ext[S-1:0];
            if (w_within) begin
                n_snap     = (r_snap == {C{1'b1}}) ? r_snap : r_snap + {{(C-1){1'b0}}, 1'b1};
                n_baseline = w_base_sum[V-1:0];
            end else begin
                n_miss = (r_miss == {C{1'b1}}) ? r_miss : r_miss + {{(C-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= '0;
            r_snap     <= '0;
            r_miss     <= '0;
            r_peak     <= '0;
            r_sum      <= '0;
        end else if (i_fire) begin
            r_baseline <= n_baseline;
            r_snap     <= n_snap;
            r_miss     <= n_miss;
            r_peak     <= n_peak;
            r_sum      <= n_sum;
        end
    end

    assign o_snap_total = n_snap;
    assign o_miss_total = n_miss;
    assign o_peak_delta = n_peak;
    assign o_delta_sum  = n_sum;

endmodule

`default_nettype wire
